### hw/rtl/pfx_pkg.sv
package pfx_pkg;

  localparam int unsigned StackDepthDefault = 16;
  localparam int unsigned TokenLimitDefault = 16;
  localparam int unsigned ValueWidthDefault = 32;

  localparam logic [7:0] CharPlus  = 8'h2b;
  localparam logic [7:0] CharMinus = 8'h2d;
  localparam logic [7:0] CharStar  = 8'h2a;
  localparam logic [7:0] CharSlash = 8'h2f;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharNl    = 8'h0a;

  typedef enum logic [2:0] {
    ErrNone     = 3'd0,
    ErrOperand  = 3'd1,
    ErrOperator = 3'd2,
    ErrFewOps   = 3'd3,
    ErrLong     = 3'd4,
    ErrDivZero  = 3'd5,
    ErrOverflow = 3'd6
  } err_e;

  typedef enum logic [2:0] {
    OpPush   = 3'd0,
    OpAdd    = 3'd1,
    OpSub    = 3'd2,
    OpMul    = 3'd3,
    OpDiv    = 3'd4,
    OpErr    = 3'd5,
    OpLine   = 3'd6
  } op_e;

  typedef struct packed {
    logic [7:0] char_in;
    logic       stream_end;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               valid_res;
    logic [2:0]         error_code;
  } out_item_t;

endpackage

### hw/rtl/pfx_front.sv
module pfx_front
  import pfx_pkg::*;
#(
  parameter int unsigned TokenLimit = TokenLimitDefault,
  parameter int unsigned ValueWidth = ValueWidthDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  in_item_t              in_item_i,
  output logic                  in_ready_o,
  output logic                  cmd_valid_o,
  output op_e                   cmd_op_o,
  output logic [ValueWidth-1:0] cmd_val_o,
  output err_e                  cmd_err_o,
  input  logic                  cmd_ready_i
);

  localparam int unsigned LenW = $clog2(TokenLimit + 1);

  logic [LenW-1:0]       len_q, len_d;
  logic [7:0]            first_q, first_d;
  logic [ValueWidth-1:0] mag_q, mag_d;
  logic                  alld_q, alld_d, sec_q, sec_d;
  logic                  err_q, err_d, has_q, has_d;
  logic                  pend_q, pend_d;
  logic                  cv;
  op_e                   cop;
  err_e                  cerr;
  logic [ValueWidth-1:0] cval;
  logic [7:0]            c;
  logic                  is_d, brk, eol, fin, neg;
  logic [ValueWidth-1:0] dig;

  assign c    = in_item_i.char_in;
  assign eol  = in_item_i.stream_end || (c == CharNl);
  assign brk  = (c == CharSpace) || (c == CharTab);
  assign is_d = (c >= CharZero) && (c <= CharNine);
  assign dig  = ValueWidth'(c - CharZero);
  assign neg  = (first_q == CharMinus) && (len_q >= LenW'(2)) && sec_q;
  assign fin  = (len_q != '0) && !err_q && (eol || brk);

  always_comb begin
    cop  = OpErr;
    cerr = ErrNone;
    cval = '0;
    if ((first_q >= CharZero && first_q <= CharNine) || neg) begin
      if (!alld_q) begin
        cerr = ErrOperand;
      end else begin
        cop  = OpPush;
        cval = neg ? ValueWidth'(-mag_q) : mag_q;
      end
    end else if (len_q > LenW'(1)) begin
      cerr = ErrOperator;
    end else begin
      unique case (first_q)
        CharPlus:  cop = OpAdd;
        CharMinus: cop = OpSub;
        CharStar:  cop = OpMul;
        CharSlash: cop = OpDiv;
        default:   cerr = ErrOperator;
      endcase
    end
  end

  // A line end that also finishes a token takes two queue transfers.
  assign in_ready_o = cmd_ready_i && !pend_q;

  always_comb begin
    len_d = len_q; first_d = first_q; mag_d = mag_q; alld_d = alld_q;
    sec_d = sec_q; err_d = err_q; has_d = has_q; pend_d = pend_q;
    cv = 1'b0; cmd_op_o = cop; cmd_val_o = cval; cmd_err_o = cerr;
    if (pend_q) begin
      cv = 1'b1; cmd_op_o = OpLine; cmd_err_o = ErrNone;
      if (cmd_ready_i) begin
        pend_d = 1'b0; len_d = '0; err_d = 1'b0; has_d = 1'b0;
      end
    end else if (in_valid_i && cmd_ready_i) begin
      if (eol) begin
        if (fin) begin
          cv = 1'b1;
          pend_d = has_q;
          if (!has_q) begin
            len_d = '0; err_d = 1'b0;
          end
        end else begin
          cv = has_q; cmd_op_o = OpLine; cmd_err_o = ErrNone;
          len_d = '0; err_d = 1'b0; has_d = 1'b0;
        end
      end else if (!err_q) begin
        if (brk) begin
          if (len_q != '0) begin
            cv = 1'b1; len_d = '0;
            if (cop == OpErr) err_d = 1'b1;
          end
        end else begin
          has_d = 1'b1;
          if (len_q >= LenW'(TokenLimit - 1)) begin
            cv = 1'b1; cmd_op_o = OpErr; cmd_err_o = ErrLong; err_d = 1'b1;
          end else begin
            if (len_q == '0) begin
              first_d = c; alld_d = 1'b1; sec_d = 1'b0;
              mag_d = is_d ? dig : '0;
            end else begin
              if (len_q == LenW'(1)) sec_d = is_d;
              if (!is_d) alld_d = 1'b0;
              else mag_d = ValueWidth'(mag_q * ValueWidth'(10)) + dig;
            end
            len_d = len_q + LenW'(1);
          end
        end
      end
    end
  end

  assign cmd_valid_o = cv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0; first_q <= '0; mag_q <= '0; alld_q <= 1'b1; sec_q <= 1'b0;
      err_q <= 1'b0; has_q <= 1'b0; pend_q <= 1'b0;
    end else begin
      len_q <= len_d; first_q <= first_d; mag_q <= mag_d; alld_q <= alld_d;
      sec_q <= sec_d; err_q <= err_d; has_q <= has_d; pend_q <= pend_d;
    end
  end

endmodule

### hw/rtl/pfx_fifo.sv
module pfx_fifo
  import pfx_pkg::*;
#(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  input  logic [Width-1:0] wr_data_i,
  output logic             wr_ready_o,
  output logic             rd_valid_o,
  output logic [Width-1:0] rd_data_o,
  input  logic             rd_ready_i
);

  logic [Width-1:0] mem_q [2];
  logic             wp_q, rp_q;
  logic [1:0]       cnt_q;
  logic             wr, rd;

  assign wr_ready_o = cnt_q != 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wp_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (wr) wp_q <= !wp_q;
      if (rd) rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

### hw/rtl/pfx_back.sv
module pfx_back
  import pfx_pkg::*;
#(
  parameter int unsigned StackDepth = StackDepthDefault,
  parameter int unsigned ValueWidth = ValueWidthDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_valid_i,
  input  op_e                   cmd_op_i,
  input  logic [ValueWidth-1:0] cmd_val_i,
  input  err_e                  cmd_err_i,
  output logic                  cmd_ready_o,
  output logic                  empty,
  output out_item_t             res_o,
  input  logic                  pop
);

  localparam int unsigned CntW = $clog2(StackDepth + 1);
  localparam int unsigned IdxW = (StackDepth > 1) ? $clog2(StackDepth) : 1;
  localparam int unsigned DivW = $clog2(ValueWidth + 1);

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SRdB  = 3'd1;
  localparam logic [2:0] SRdA  = 3'd2;
  localparam logic [2:0] SExec = 3'd3;
  localparam logic [2:0] SDiv  = 3'd4;
  localparam logic [2:0] SRdT  = 3'd5;
  localparam logic [2:0] SOut  = 3'd6;

  logic [ValueWidth-1:0] stk_q [StackDepth];
  logic [ValueWidth-1:0] rdata_q;
  logic [IdxW-1:0]       raddr;
  logic                  ren;
  logic [2:0]            st_q, st_d;
  logic [CntW-1:0]       cnt_q;
  err_e                  err_q;
  logic                  vld_q;
  op_e                   op_q;
  logic [ValueWidth-1:0] a_q, b_q;
  logic [ValueWidth-1:0] quo_q, rem_q;
  logic [DivW-1:0]       dcnt_q;
  logic                  dneg_q;
  logic                  obusy_q;
  out_item_t             obuf_q;
  logic                  wen;
  logic [IdxW-1:0]       waddr;
  logic [ValueWidth-1:0] wdata, sum, mag_a, mag_b, rsh;
  logic [ValueWidth:0]   trial;
  logic [2*ValueWidth-1:0] prod;

  assign empty = !obusy_q;
  assign res_o = obuf_q;
  assign cmd_ready_o = (st_q == SIdle) && !(cmd_op_i == OpLine && obusy_q && !pop);

  always_ff @(posedge clk_i) begin
    if (wen) stk_q[waddr] <= wdata;
    if (ren) rdata_q <= stk_q[raddr];
  end

  assign prod = a_q * b_q;
  assign mag_a = a_q[ValueWidth-1] ? ValueWidth'(-a_q) : a_q;
  assign mag_b = b_q[ValueWidth-1] ? ValueWidth'(-b_q) : b_q;
  assign rsh = {rem_q[ValueWidth-2:0], quo_q[ValueWidth-1]};
  assign trial = {1'b0, rsh} - {1'b0, b_q};

  always_comb begin
    unique case (op_q)
      OpAdd:   sum = a_q + b_q;
      OpSub:   sum = a_q - b_q;
      OpMul:   sum = prod[ValueWidth-1:0];
      default: sum = dneg_q ? ValueWidth'(-quo_q) : quo_q;
    endcase
  end

  always_comb begin
    st_d = st_q; ren = 1'b0; raddr = '0; wen = 1'b0;
    waddr = IdxW'(cnt_q); wdata = cmd_val_i;
    unique case (st_q)
      SIdle: begin
        if (cmd_valid_i && cmd_ready_o) begin
          unique case (cmd_op_i)
            OpPush: if (err_q == ErrNone && cnt_q < CntW'(StackDepth)) wen = 1'b1;
            OpAdd, OpSub, OpMul, OpDiv: begin
              if (err_q == ErrNone && cnt_q >= CntW'(2)) begin
                ren = 1'b1; raddr = IdxW'(cnt_q - CntW'(1)); st_d = SRdB;
              end
            end
            OpLine: begin
              if (cnt_q != '0) begin
                ren = 1'b1; raddr = IdxW'(cnt_q - CntW'(1));
              end
              st_d = SRdT;
            end
            default: ;
          endcase
        end
      end
      SRdB: begin
        ren = 1'b1; raddr = IdxW'(cnt_q - CntW'(2)); st_d = SRdA;
      end
      SRdA: st_d = SExec;
      SExec: begin
        if (op_q == OpDiv) begin
          st_d = (b_q == '0) ? SIdle : SDiv;
        end else begin
          wen = 1'b1; waddr = IdxW'(cnt_q - CntW'(2)); wdata = sum; st_d = SIdle;
        end
      end
      SDiv: begin
        if (dcnt_q == '0) begin
          wen = 1'b1; waddr = IdxW'(cnt_q - CntW'(2)); wdata = sum; st_d = SIdle;
        end
      end
      SRdT: st_d = SOut;
      SOut: st_d = SIdle;
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; cnt_q <= '0; err_q <= ErrNone; vld_q <= 1'b0;
      obusy_q <= 1'b0; op_q <= OpPush; dcnt_q <= '0; dneg_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == SOut) obusy_q <= 1'b1;
      else if (pop && obusy_q) obusy_q <= 1'b0;
      unique case (st_q)
        SIdle: begin
          if (cmd_valid_i && cmd_ready_o && cmd_op_i != OpLine && err_q == ErrNone) begin
            op_q <= cmd_op_i; vld_q <= 1'b0;
            unique case (cmd_op_i)
              OpPush: begin
                if (cnt_q < CntW'(StackDepth)) cnt_q <= cnt_q + CntW'(1);
                else err_q <= ErrOverflow;
              end
              OpErr: err_q <= cmd_err_i;
              default: if (cnt_q < CntW'(2)) err_q <= ErrFewOps;
            endcase
          end
        end
        SRdB: b_q <= rdata_q;
        SRdA: a_q <= rdata_q;
        SExec: begin
          if (op_q == OpDiv) begin
            if (b_q == '0) begin
              err_q <= ErrDivZero;
            end else begin
              dneg_q <= a_q[ValueWidth-1] ^ b_q[ValueWidth-1];
              quo_q <= mag_a;
              rem_q <= '0; b_q <= mag_b; dcnt_q <= DivW'(ValueWidth);
            end
          end else begin
            cnt_q <= cnt_q - CntW'(1); vld_q <= (cnt_q == CntW'(2));
          end
        end
        SDiv: begin
          if (dcnt_q == '0) begin
            cnt_q <= cnt_q - CntW'(1); vld_q <= (cnt_q == CntW'(2));
          end else begin
            dcnt_q <= dcnt_q - DivW'(1);
            if (!trial[ValueWidth]) begin
              rem_q <= trial[ValueWidth-1:0]; quo_q <= {quo_q[ValueWidth-2:0], 1'b1};
            end else begin
              rem_q <= rsh; quo_q <= {quo_q[ValueWidth-2:0], 1'b0};
            end
          end
        end
        SRdT: ;
        SOut: begin
          obuf_q.value <= (cnt_q == '0) ? '0 : 32'(signed'(rdata_q));
          obuf_q.valid_res <= (err_q == ErrNone) && vld_q;
          obuf_q.error_code <= err_q;
          cnt_q <= '0; err_q <= ErrNone; vld_q <= 1'b0;
        end
        default: ;
      endcase
    end
  end

endmodule

### hw/rtl/postfix_expression_evaluator.sv
// Postfix expression evaluator.
// Input channel: push/full with in_i carrying one text byte and a stream end
// flag; a transfer happens on a clock edge with push high and full low.
// Result channel: empty/pop with res_o holding the oldest line result; a
// transfer happens on a clock edge with pop high and empty low.
// One result is produced for each line that held at least one token.
// A front tokenizer takes one byte per cycle into a two-entry command queue,
// while the queue has room and the front holds no pending line end command.
// The back stack engine executes a push with one stack memory write, an add,
// subtract or multiply with two stack memory reads and a write, and a divide
// through its radix-2 restoring divider.
// A line end that closes a token takes two queue transfers in the front.
// A result waits in a one-entry output register; while it is not taken,
// the back holds the next line end and the queue fills, raising full.
// Reset clears the token state, the stack count and the output register's busy flag;
// stack entries are not cleared and are only read once written.
module postfix_expression_evaluator
  import pfx_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = StackDepthDefault,
  parameter int unsigned TOKEN_LIMIT = TokenLimitDefault,
  parameter int unsigned VALUE_WIDTH = ValueWidthDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  input  in_item_t  in_i,
  output logic      full,
  output logic      empty,
  output out_item_t res_o,
  input  logic      pop
);

  localparam int unsigned CmdW = 3 + VALUE_WIDTH + 3;

  logic                   fv, fr, bv, br, ready;
  op_e                    fop;
  err_e                   ferr;
  logic [VALUE_WIDTH-1:0] fval;
  logic [CmdW-1:0]        qin, qout;

  assign full = !ready;

  pfx_front #(.TokenLimit(TOKEN_LIMIT), .ValueWidth(VALUE_WIDTH)) u_front (
    .clk_i, .rst_ni, .in_valid_i(push), .in_item_i(in_i), .in_ready_o(ready),
    .cmd_valid_o(fv), .cmd_op_o(fop), .cmd_val_o(fval), .cmd_err_o(ferr),
    .cmd_ready_i(fr)
  );

  assign qin = {fop, fval, ferr};

  pfx_fifo #(.Width(CmdW)) u_fifo (
    .clk_i, .rst_ni, .wr_valid_i(fv), .wr_data_i(qin), .wr_ready_o(fr),
    .rd_valid_o(bv), .rd_data_o(qout), .rd_ready_i(br)
  );

  pfx_back #(.StackDepth(STACK_DEPTH), .ValueWidth(VALUE_WIDTH)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(bv), .cmd_op_i(op_e'(qout[CmdW-1 -: 3])),
    .cmd_val_i(qout[3 +: VALUE_WIDTH]), .cmd_err_i(err_e'(qout[2:0])),
    .cmd_ready_o(br), .empty, .res_o, .pop
  );

endmodule

### hw/rtl/pfx_checker.sv
module pfx_checker
  import pfx_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      push,
  input logic      full,
  input logic      empty,
  input out_item_t res_o,
  input logic      pop
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(res_o)) else $error("result changed while stalled");
  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> res_o.error_code <= ErrOverflow) else $error("bad error code");
  a_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && res_o.valid_res |-> res_o.error_code == ErrNone) else $error("valid with error");
  a_rst: assert property (@(posedge clk_i) $rose(rst_ni) |-> empty && !full)
    else $error("result after reset");
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !$isunknown(full)) else $error("full unknown");

endmodule

bind postfix_expression_evaluator pfx_checker u_checker (
  .clk_i, .rst_ni, .push, .full, .empty, .res_o, .pop
);
